@@ hw/rtl/csl_pkg.sv @@
package csl_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int CNT_W       = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                    func;
        logic signed [VALUE_WIDTH-1:0] item_value;
        logic [SLOT_W-1:0]             slot_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [SLOT_W-1:0]             slot_used;
        logic signed [VALUE_WIDTH-1:0] read_value;
        logic                          slot_occupied;
        logic [COUNT_W-1:0]            entry_count;
        logic [CNT_W-1:0]              move_total;
        logic [CNT_W-1:0]              compare_total;
    } out_item_t;

endpackage

@@ hw/rtl/compacting_slot_list_top.sv @@
// A result is registered when its input is accepted. Throughput: one
// transaction per cycle unless the sink stalls; the next is taken while a
// result is being handed over, set by the single output register.
// Reset (aresetn low, synchronous): table empty, counters zero, bottom fill,
// output register empty. Slot values are not cleared.
module compacting_slot_list_top
    import csl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_wdata
);

    logic [VALUE_WIDTH-1:0] slot_val_reg  [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] slot_val_next [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] from_above    [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] from_below    [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  full_reg, full_next;
    logic [COUNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]       moves_reg, moves_next;
    logic [CNT_W-1:0]       cmps_reg, cmps_next;
    logic                   top_mode_reg;
    logic                   m_valid_reg;
    out_item_t              out_reg, out_next;

    logic                   accept;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic [COUNT_W-1:0]     probes;
    logic [SLOT_COUNT-1:0]  gap_bits;
    logic                   gap_found;
    logic [SLOT_W-1:0]      gap_pos;
    logic [SLOT_W-1:0]      run_end;
    logic [SLOT_W-1:0]      steps;
    logic [SLOT_W-1:0]      idx;
    logic                   idx_full;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    assign accept    = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
    assign idx       = s_data.slot_index;
    assign idx_full  = full_reg[idx];

    always_comb begin
        for (int s = 0; s < SLOT_COUNT - 1; s++) begin
            from_above[s]     = slot_val_reg[s+1];
            from_below[s + 1] = slot_val_reg[s];
        end
        from_above[SLOT_COUNT-1] = slot_val_reg[SLOT_COUNT-1];
        from_below[0]            = slot_val_reg[0];
    end

    // first free slot in fill order
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        if (top_mode_reg) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (!full_reg[s]) begin
                    free_found = 1'b1;
                    free_slot  = SLOT_W'(s);
                end
            end
        end else begin
            for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
                if (!full_reg[s]) begin
                    free_found = 1'b1;
                    free_slot  = SLOT_W'(s);
                end
            end
        end
        if (!free_found) begin
            probes = COUNT_W'(SLOT_COUNT);
        end else if (top_mode_reg) begin
            probes = COUNT_W'(SLOT_COUNT) - {1'b0, free_slot};
        end else begin
            probes = {1'b0, free_slot} + COUNT_W'(1);
        end
    end

    // nearest free slot beyond the removed one, in the shift direction
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            gap_bits[s] = !full_reg[s] &&
                          (top_mode_reg ? (SLOT_W'(s) < idx) : (SLOT_W'(s) > idx));
        end
        gap_found = 1'b0;
        gap_pos   = '0;
        if (top_mode_reg) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (gap_bits[s]) begin
                    gap_found = 1'b1;
                    gap_pos   = SLOT_W'(s);
                end
            end
            run_end = gap_found ? gap_pos + SLOT_W'(1) : '0;
            steps   = idx - run_end;
        end else begin
            for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
                if (gap_bits[s]) begin
                    gap_found = 1'b1;
                    gap_pos   = SLOT_W'(s);
                end
            end
            run_end = gap_found ? gap_pos - SLOT_W'(1) : SLOT_W'(SLOT_COUNT - 1);
            steps   = run_end - idx;
        end
    end

    always_comb begin
        slot_val_next = slot_val_reg;
        full_next     = full_reg;
        held_next     = held_reg;
        moves_next    = moves_reg;
        cmps_next     = cmps_reg;
        out_next      = '0;
        out_next.slot_used = idx;
        case (s_data.func)
            FUNC_INSERT: begin
                cmps_next = sat_add(cmps_reg, CNT_W'(probes));
                if (free_found) begin
                    slot_val_next[free_slot] = s_data.item_value;
                    full_next[free_slot]     = 1'b1;
                    held_next                = held_reg + COUNT_W'(1);
                    out_next.slot_used       = free_slot;
                end else begin
                    out_next.status    = STATUS_FULL;
                    out_next.slot_used = '0;
                end
            end
            FUNC_REMOVE: begin
                if (!idx_full) begin
                    out_next.status = STATUS_EMPTY;
                end else begin
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (top_mode_reg) begin
                            if (SLOT_W'(s) > run_end && SLOT_W'(s) <= idx) begin
                                slot_val_next[s] = from_below[s];
                            end
                        end else begin
                            if (SLOT_W'(s) >= idx && SLOT_W'(s) < run_end) begin
                                slot_val_next[s] = from_above[s];
                            end
                        end
                    end
                    full_next[run_end] = 1'b0;
                    held_next          = held_reg - COUNT_W'(1);
                    moves_next         = sat_add(moves_reg, CNT_W'(steps));
                    cmps_next          = sat_add(cmps_reg, CNT_W'(steps));
                end
            end
            FUNC_CLEAR: begin
                full_next          = '0;
                held_next          = '0;
                out_next.slot_used = '0;
            end
            FUNC_READ: begin
                if (idx_full) begin
                    out_next.slot_occupied = 1'b1;
                    out_next.read_value    = slot_val_reg[idx];
                end
            end
            default: begin
                out_next.status = STATUS_DONE;
            end
        endcase
        out_next.entry_count   = held_next;
        out_next.move_total    = moves_next;
        out_next.compare_total = cmps_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg     <= '0;
            held_reg     <= '0;
            moves_reg    <= '0;
            cmps_reg     <= '0;
            top_mode_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                top_mode_reg <= cfg_wdata;
            end
            if (accept) begin
                full_reg    <= full_next;
                held_reg    <= held_next;
                moves_reg   <= moves_next;
                cmps_reg    <= cmps_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_val_reg <= slot_val_next;
            out_reg      <= out_next;
        end
    end

endmodule

@@ hw/rtl/csl_checker.sv @@
module csl_checker
    import csl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a result waiting on the sink is not dropped
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after accepted transaction");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= COUNT_W'(SLOT_COUNT))
        else $error("entry count beyond table size");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |->
            m_data.entry_count == COUNT_W'(SLOT_COUNT))
        else $error("full reported with free slots");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_EMPTY |->
            !m_data.slot_occupied && m_data.read_value == '0)
        else $error("empty remove returned data");

endmodule

bind compacting_slot_list_top csl_checker u_csl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
